>>> src/acpc_pkg.sv
// ----------------------------------------------------------------------------
// acpc_pkg
// Shared types and constants of the Aho-Corasick pattern counter.
// ----------------------------------------------------------------------------
package acpc_pkg;

   // default sizes of the automaton
   localparam int ALPHABET_DEF        = 128;
   localparam int NODES_DEF           = 4096;
   localparam int PATTERNS_DEF        = 1024;
   localparam int MAX_PATTERN_LEN_DEF = 32;

   // fixed field widths of the channels
   localparam int OPCODE_W = 3;
   localparam int SYMBOL_W = 7;
   localparam int QUERY_W  = 11;
   localparam int PID_W    = 11;
   localparam int COUNT_W  = 32;

   // results reported per scan symbol
   localparam int OUT_MAX = 32;
   localparam int K_W     = $clog2(OUT_MAX + 1);

   // command queue between front and back
   localparam int CMD_FIFO_DEPTH = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_CLEAR  = 3'd0,
      OP_INSERT = 3'd1,
      OP_BUILD  = 3'd2,
      OP_SCAN   = 3'd3,
      OP_READ   = 3'd4
   } opcode_type;

   typedef enum logic [2:0] {
      CMD_CLEAR,
      CMD_INSERT,
      CMD_BUILD,
      CMD_SCAN,
      CMD_READ,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [SYMBOL_W-1:0] symbol;
      logic                pattern_end;
      logic [QUERY_W-1:0]  query_id;
      logic                symbol_ok;   // symbol inside the alphabet
      logic                query_ok;    // query id inside 1..PATTERNS
   } cmd_type;

   typedef enum logic [4:0] {
      ST_CLR,
      ST_IDLE,
      ST_ACK,
      ST_ACK_CLR,
      ST_INS0,
      ST_INS_RD,
      ST_INS_ROW,
      ST_INS_END,
      ST_BR,
      ST_BR_CHK,
      ST_BP,
      ST_BP2,
      ST_BP3,
      ST_BC1,
      ST_BC2,
      ST_BC3,
      ST_BDONE,
      ST_SC0,
      ST_SC1,
      ST_CH,
      ST_CH2,
      ST_CH3,
      ST_CH4,
      ST_SC_FIN,
      ST_RD0,
      ST_RD1
   } back_state_type;

endpackage

>>> src/acpc_if.sv
// ----------------------------------------------------------------------------
// acpc_req_if / acpc_rsp_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface acpc_req_if;
   logic                           valid;
   logic                           ready;
   logic [acpc_pkg::OPCODE_W-1:0]  opcode;
   logic [acpc_pkg::SYMBOL_W-1:0]  symbol;
   logic                           pattern_end;
   logic [acpc_pkg::QUERY_W-1:0]   query_id;

   modport source (output valid, opcode, symbol, pattern_end, query_id, input ready);
   modport sink   (input valid, opcode, symbol, pattern_end, query_id, output ready);
endinterface

interface acpc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [acpc_pkg::PID_W-1:0]     pattern_id;
   logic [acpc_pkg::COUNT_W-1:0]   match_count;
   logic                           matched;
   logic                           overflow;
   logic                           last;

   modport source (output valid, pattern_id, match_count, matched, overflow, last,
                   input ready);
   modport sink   (input valid, pattern_id, match_count, matched, overflow, last,
                   output ready);
endinterface

>>> src/acpc_ram.sv
// ----------------------------------------------------------------------------
// acpc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module acpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

>>> src/acpc_front.sv
// ----------------------------------------------------------------------------
// acpc_front
// Takes command items, decodes them and holds them in a short queue.
// ----------------------------------------------------------------------------
module acpc_front #(
   parameter int ALPHABET = acpc_pkg::ALPHABET_DEF,
   parameter int PATTERNS = acpc_pkg::PATTERNS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   acpc_req_if.sink          req_ch,
   input  logic              hold,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output acpc_pkg::cmd_type cmd
);

   localparam int DEPTH = acpc_pkg::CMD_FIFO_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   acpc_pkg::cmd_type fifo_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   acpc_pkg::cmd_type dec;
   logic              push;
   logic              pop;

   always_comb begin
      dec.symbol      = req_ch.symbol;
      dec.pattern_end = req_ch.pattern_end;
      dec.query_id    = req_ch.query_id;
      dec.symbol_ok   = (32'(req_ch.symbol) < ALPHABET);
      dec.query_ok    = (req_ch.query_id != '0) && (32'(req_ch.query_id) <= PATTERNS);
      case (req_ch.opcode)
         acpc_pkg::OP_CLEAR:  dec.kind = acpc_pkg::CMD_CLEAR;
         acpc_pkg::OP_INSERT: dec.kind = acpc_pkg::CMD_INSERT;
         acpc_pkg::OP_BUILD:  dec.kind = acpc_pkg::CMD_BUILD;
         acpc_pkg::OP_SCAN:   dec.kind = acpc_pkg::CMD_SCAN;
         acpc_pkg::OP_READ:   dec.kind = acpc_pkg::CMD_READ;
         default:             dec.kind = acpc_pkg::CMD_NOP;
      endcase
   end

   assign req_ch.ready = (count_ff != CNT_W'(DEPTH)) && !hold;
   assign push         = req_ch.valid && req_ch.ready;
   assign cmd_valid    = (count_ff != '0);
   assign pop          = cmd_valid && cmd_ready;
   assign cmd          = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         fifo_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

>>> src/acpc_back.sv
// ----------------------------------------------------------------------------
// acpc_back
// Executes decoded commands against the automaton memories and issues
// results through an output register.
// ----------------------------------------------------------------------------
module acpc_back #(
   parameter int ALPHABET        = acpc_pkg::ALPHABET_DEF,
   parameter int NODES           = acpc_pkg::NODES_DEF,
   parameter int PATTERNS        = acpc_pkg::PATTERNS_DEF,
   parameter int MAX_PATTERN_LEN = acpc_pkg::MAX_PATTERN_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  acpc_pkg::cmd_type cmd,
   output logic              clearing,
   acpc_rsp_if.source        rsp_ch
);

   localparam int NODE_W = $clog2(NODES);
   localparam int GA_W   = $clog2(NODES * ALPHABET);
   localparam int CW     = $clog2(ALPHABET);
   localparam int DW     = $clog2(MAX_PATTERN_LEN + 1);
   localparam int ID_W   = $clog2(PATTERNS + 1);
   localparam int CTW    = acpc_pkg::COUNT_W;
   localparam int K_W    = acpc_pkg::K_W;

   function automatic logic [GA_W-1:0] gaddr(input logic [NODE_W-1:0] n,
                                              input logic [GA_W-1:0]   s);
      return GA_W'(GA_W'(n) * GA_W'(ALPHABET) + s);
   endfunction

   acpc_pkg::back_state_type state_ff, state_in;
   acpc_pkg::cmd_type        cmd_ff, cmd_in;
   logic [NODE_W-1:0] nodes_used_ff, nodes_used_in;
   logic [ID_W-1:0]   pu_ff, pu_in;
   logic [NODE_W-1:0] ins_node_ff, ins_node_in;
   logic [DW-1:0]     ins_depth_ff, ins_depth_in;
   logic              ins_broken_ff, ins_broken_in;
   logic              built_ff, built_in;
   logic [NODE_W-1:0] scan_node_ff, scan_node_in;
   logic              ovf_ff, ovf_in;
   logic [CW-1:0]     lc_ff, lc_in;
   logic [NODE_W-1:0] head_ff, head_in;
   logic [NODE_W-1:0] tail_ff, tail_in;
   logic [NODE_W-1:0] n_ff, n_in;
   logic [NODE_W-1:0] f_ff, f_in;
   logic [NODE_W-1:0] ch_ff, ch_in;
   logic [NODE_W-1:0] j_ff, j_in;
   logic [ID_W-1:0]   pid_ff, pid_in;
   logic [CTW-1:0]    nc_ff, nc_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]   pend_pid_ff, pend_pid_in;
   logic [CTW-1:0]    pend_cnt_ff, pend_cnt_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [acpc_pkg::PID_W-1:0]    rsp_pid_ff, rsp_pid_in;
   logic [CTW-1:0]                rsp_cnt_ff, rsp_cnt_in;
   logic                          rsp_hit_ff, rsp_hit_in;
   logic                          rsp_ovf_ff, rsp_ovf_in;
   logic                          rsp_last_ff, rsp_last_in;

   // result issued this cycle
   logic                          emit;
   logic [acpc_pkg::PID_W-1:0]    e_pid;
   logic [CTW-1:0]                e_cnt;
   logic                          e_hit;
   logic                          e_ovf;
   logic                          e_last;
   logic                          out_free;

   // memory ports
   logic              g_we;
   logic [GA_W-1:0]   g_waddr, g_raddr;
   logic [NODE_W-1:0] g_wdata, g_rd;
   logic              fl_we;
   logic [NODE_W-1:0] fl_waddr, fl_raddr, fl_wdata, fl_rd;
   logic              np_we;
   logic [NODE_W-1:0] np_waddr, np_raddr;
   logic [ID_W-1:0]   np_wdata, np_rd;
   logic              ct_we;
   logic [ID_W-1:0]   ct_waddr, ct_raddr;
   logic [CTW-1:0]    ct_wdata, ct_rd;
   logic              q_we;
   logic [NODE_W-1:0] q_waddr, q_raddr, q_wdata, q_rd;

   logic              lc_last;
   logic              end_ok;

   acpc_ram #(.WIDTH(NODE_W), .DEPTH(NODES * ALPHABET)) u_goto (
      .clock(clock), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
      .raddr(g_raddr), .rdata(g_rd));
   acpc_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_fail (
      .clock(clock), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
      .raddr(fl_raddr), .rdata(fl_rd));
   acpc_ram #(.WIDTH(ID_W), .DEPTH(NODES)) u_npat (
      .clock(clock), .we(np_we), .waddr(np_waddr), .wdata(np_wdata),
      .raddr(np_raddr), .rdata(np_rd));
   acpc_ram #(.WIDTH(CTW), .DEPTH(PATTERNS + 1)) u_count (
      .clock(clock), .we(ct_we), .waddr(ct_waddr), .wdata(ct_wdata),
      .raddr(ct_raddr), .rdata(ct_rd));
   acpc_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_bfsq (
      .clock(clock), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
      .raddr(q_raddr), .rdata(q_rd));

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign clearing = (state_ff == acpc_pkg::ST_CLR);
   assign lc_last  = (lc_ff == CW'(ALPHABET - 1));
   // an end mark that may take a new id
   assign end_ok   = cmd_ff.pattern_end && !ins_broken_ff && (pu_ff != ID_W'(PATTERNS));

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      nodes_used_in = nodes_used_ff;
      pu_in         = pu_ff;
      ins_node_in   = ins_node_ff;
      ins_depth_in  = ins_depth_ff;
      ins_broken_in = ins_broken_ff;
      built_in      = built_ff;
      scan_node_in  = scan_node_ff;
      ovf_in        = ovf_ff;
      lc_in         = lc_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      n_in          = n_ff;
      f_in          = f_ff;
      ch_in         = ch_ff;
      j_in          = j_ff;
      pid_in        = pid_ff;
      nc_in         = nc_ff;
      k_in          = k_ff;
      pend_valid_in = pend_valid_ff;
      pend_pid_in   = pend_pid_ff;
      pend_cnt_in   = pend_cnt_ff;

      cmd_ready = 1'b0;
      emit      = 1'b0;
      e_pid     = '0;
      e_cnt     = '0;
      e_hit     = 1'b0;
      e_ovf     = 1'b0;
      e_last    = 1'b1;

      g_we     = 1'b0;
      g_waddr  = '0;
      g_wdata  = '0;
      g_raddr  = '0;
      fl_we    = 1'b0;
      fl_waddr = '0;
      fl_wdata = '0;
      fl_raddr = '0;
      np_we    = 1'b0;
      np_waddr = '0;
      np_wdata = '0;
      np_raddr = '0;
      ct_we    = 1'b0;
      ct_waddr = '0;
      ct_wdata = '0;
      ct_raddr = '0;
      q_we     = 1'b0;
      q_waddr  = '0;
      q_wdata  = '0;
      q_raddr  = '0;

      case (state_ff)
         acpc_pkg::ST_CLR: begin
            // root row back to all-root edges
            g_we    = 1'b1;
            g_waddr = GA_W'(lc_ff);
            lc_in   = lc_ff + 1'b1;
            if (lc_last) begin
               lc_in    = '0;
               state_in = acpc_pkg::ST_IDLE;
            end
         end

         acpc_pkg::ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in = cmd;
               ovf_in = 1'b0;
               case (cmd.kind)
                  acpc_pkg::CMD_CLEAR:  state_in = acpc_pkg::ST_ACK_CLR;
                  acpc_pkg::CMD_INSERT: state_in = acpc_pkg::ST_INS0;
                  acpc_pkg::CMD_BUILD: begin
                     lc_in    = '0;
                     tail_in  = '0;
                     state_in = built_ff ? acpc_pkg::ST_ACK : acpc_pkg::ST_BR;
                  end
                  acpc_pkg::CMD_SCAN:   state_in = acpc_pkg::ST_SC0;
                  acpc_pkg::CMD_READ:   state_in = acpc_pkg::ST_RD0;
                  default:              state_in = acpc_pkg::ST_ACK;
               endcase
            end
         end

         acpc_pkg::ST_ACK: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = acpc_pkg::ST_IDLE;
            end
         end

         acpc_pkg::ST_ACK_CLR: begin
            if (out_free) begin
               emit          = 1'b1;
               nodes_used_in = '0;
               pu_in         = '0;
               ins_node_in   = '0;
               ins_depth_in  = '0;
               ins_broken_in = 1'b0;
               built_in      = 1'b0;
               scan_node_in  = '0;
               lc_in         = '0;
               state_in      = acpc_pkg::ST_CLR;
            end
         end

         acpc_pkg::ST_INS0: begin
            g_raddr = gaddr(ins_node_ff, GA_W'(cmd_ff.symbol));
            if (built_ff || ins_broken_ff || !cmd_ff.symbol_ok ||
                ins_depth_ff >= DW'(MAX_PATTERN_LEN)) begin
               ovf_in        = 1'b1;
               ins_broken_in = 1'b1;
               state_in      = acpc_pkg::ST_INS_END;
            end else begin
               state_in = acpc_pkg::ST_INS_RD;
            end
         end

         acpc_pkg::ST_INS_RD: begin
            if (g_rd != '0) begin
               ins_node_in  = g_rd;
               ins_depth_in = ins_depth_ff + 1'b1;
               state_in     = acpc_pkg::ST_INS_END;
            end else if (nodes_used_ff == NODE_W'(NODES - 1)) begin
               ovf_in        = 1'b1;
               ins_broken_in = 1'b1;
               state_in      = acpc_pkg::ST_INS_END;
            end else begin
               // new node: link it and clear its pattern, failure link and row
               nodes_used_in = nodes_used_ff + 1'b1;
               g_we          = 1'b1;
               g_waddr       = gaddr(ins_node_ff, GA_W'(cmd_ff.symbol));
               g_wdata       = nodes_used_ff + 1'b1;
               fl_we         = 1'b1;
               fl_waddr      = nodes_used_ff + 1'b1;
               np_we         = 1'b1;
               np_waddr      = nodes_used_ff + 1'b1;
               ins_node_in   = nodes_used_ff + 1'b1;
               ins_depth_in  = ins_depth_ff + 1'b1;
               lc_in         = '0;
               state_in      = acpc_pkg::ST_INS_ROW;
            end
         end

         acpc_pkg::ST_INS_ROW: begin
            g_we    = 1'b1;
            g_waddr = gaddr(ins_node_ff, GA_W'(lc_ff));
            lc_in   = lc_ff + 1'b1;
            if (lc_last) begin
               lc_in    = '0;
               state_in = acpc_pkg::ST_INS_END;
            end
         end

         acpc_pkg::ST_INS_END: begin
            if (out_free) begin
               emit  = 1'b1;
               e_ovf = ovf_ff;
               if (cmd_ff.pattern_end) begin
                  if (end_ok) begin
                     pu_in    = pu_ff + 1'b1;
                     e_pid    = acpc_pkg::PID_W'(pu_ff + 1'b1);
                     np_we    = 1'b1;
                     np_waddr = ins_node_ff;
                     np_wdata = pu_ff + 1'b1;
                     ct_we    = 1'b1;
                     ct_waddr = pu_ff + 1'b1;
                  end else if (!ins_broken_ff) begin
                     e_ovf = 1'b1;   // pattern table full
                  end
                  ins_node_in   = '0;
                  ins_depth_in  = '0;
                  ins_broken_in = 1'b0;
               end
               state_in = acpc_pkg::ST_IDLE;
            end
         end

         // build: children of the root go to the queue
         acpc_pkg::ST_BR: begin
            g_raddr  = GA_W'(lc_ff);
            state_in = acpc_pkg::ST_BR_CHK;
         end

         acpc_pkg::ST_BR_CHK: begin
            if (g_rd != '0) begin
               q_we    = 1'b1;
               q_waddr = tail_ff;
               q_wdata = g_rd;
               tail_in = tail_ff + 1'b1;
            end
            lc_in = lc_ff + 1'b1;
            if (lc_last) begin
               lc_in    = '0;
               head_in  = '0;
               state_in = acpc_pkg::ST_BP;
            end else begin
               state_in = acpc_pkg::ST_BR;
            end
         end

         acpc_pkg::ST_BP: begin
            q_raddr = head_ff;
            if (head_ff == tail_ff) begin
               built_in = 1'b1;
               state_in = acpc_pkg::ST_BDONE;
            end else begin
               state_in = acpc_pkg::ST_BP2;
            end
         end

         acpc_pkg::ST_BP2: begin
            n_in     = q_rd;
            head_in  = head_ff + 1'b1;
            fl_raddr = q_rd;
            state_in = acpc_pkg::ST_BP3;
         end

         acpc_pkg::ST_BP3: begin
            f_in     = fl_rd;
            lc_in    = '0;
            state_in = acpc_pkg::ST_BC1;
         end

         acpc_pkg::ST_BC1: begin
            g_raddr  = gaddr(n_ff, GA_W'(lc_ff));
            state_in = acpc_pkg::ST_BC2;
         end

         acpc_pkg::ST_BC2: begin
            ch_in    = g_rd;
            g_raddr  = gaddr(f_ff, GA_W'(lc_ff));
            state_in = acpc_pkg::ST_BC3;
         end

         acpc_pkg::ST_BC3: begin
            // g_rd is the edge of the failure node on this symbol
            if (ch_ff != '0) begin
               fl_we    = 1'b1;
               fl_waddr = ch_ff;
               fl_wdata = g_rd;
               q_we     = 1'b1;
               q_waddr  = tail_ff;
               q_wdata  = ch_ff;
               tail_in  = tail_ff + 1'b1;
            end else begin
               g_we    = 1'b1;
               g_waddr = gaddr(n_ff, GA_W'(lc_ff));
               g_wdata = g_rd;
            end
            lc_in = lc_ff + 1'b1;
            if (lc_last) begin
               lc_in    = '0;
               state_in = acpc_pkg::ST_BP;
            end else begin
               state_in = acpc_pkg::ST_BC1;
            end
         end

         acpc_pkg::ST_BDONE: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = acpc_pkg::ST_IDLE;
            end
         end

         acpc_pkg::ST_SC0: begin
            g_raddr       = gaddr(scan_node_ff, GA_W'(cmd_ff.symbol));
            k_in          = '0;
            pend_valid_in = 1'b0;
            if (cmd_ff.symbol_ok) begin
               state_in = acpc_pkg::ST_SC1;
            end else begin
               scan_node_in = '0;
               state_in     = acpc_pkg::ST_SC_FIN;
            end
         end

         acpc_pkg::ST_SC1: begin
            scan_node_in = g_rd;
            j_in         = g_rd;
            state_in     = acpc_pkg::ST_CH;
         end

         // failure chain walk, deepest node first
         acpc_pkg::ST_CH: begin
            np_raddr = j_ff;
            fl_raddr = j_ff;
            state_in = (j_ff == '0) ? acpc_pkg::ST_SC_FIN : acpc_pkg::ST_CH2;
         end

         acpc_pkg::ST_CH2: begin
            j_in     = fl_rd;
            pid_in   = np_rd;
            ct_raddr = np_rd;
            state_in = (np_rd != '0) ? acpc_pkg::ST_CH3 : acpc_pkg::ST_CH;
         end

         acpc_pkg::ST_CH3: begin
            nc_in    = (ct_rd == '1) ? ct_rd : ct_rd + 1'b1;
            ct_we    = 1'b1;
            ct_waddr = pid_ff;
            ct_wdata = (ct_rd == '1) ? ct_rd : ct_rd + 1'b1;
            state_in = acpc_pkg::ST_CH4;
         end

         acpc_pkg::ST_CH4: begin
            if (k_ff == K_W'(acpc_pkg::OUT_MAX)) begin
               state_in = acpc_pkg::ST_CH;
            end else if (!pend_valid_ff || out_free) begin
               // the held result is not the last one any more
               if (pend_valid_ff) begin
                  emit   = 1'b1;
                  e_pid  = acpc_pkg::PID_W'(pend_pid_ff);
                  e_cnt  = pend_cnt_ff;
                  e_hit  = 1'b1;
                  e_last = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_pid_in   = pid_ff;
               pend_cnt_in   = nc_ff;
               k_in          = k_ff + 1'b1;
               state_in      = acpc_pkg::ST_CH;
            end
         end

         acpc_pkg::ST_SC_FIN: begin
            if (out_free) begin
               emit = 1'b1;
               if (pend_valid_ff) begin
                  e_pid = acpc_pkg::PID_W'(pend_pid_ff);
                  e_cnt = pend_cnt_ff;
                  e_hit = 1'b1;
               end
               state_in = acpc_pkg::ST_IDLE;
            end
         end

         acpc_pkg::ST_RD0: begin
            ct_raddr = ID_W'(cmd_ff.query_id);
            state_in = acpc_pkg::ST_RD1;
         end

         acpc_pkg::ST_RD1: begin
            ct_raddr = ID_W'(cmd_ff.query_id);
            if (out_free) begin
               emit = 1'b1;
               if (cmd_ff.query_ok) begin
                  e_pid = cmd_ff.query_id;
                  // ids above the assigned ones were never cleared
                  if (32'(cmd_ff.query_id) <= 32'(pu_ff)) begin
                     e_cnt = ct_rd;
                  end
               end
               state_in = acpc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = acpc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pid_in   = rsp_pid_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_pid_in   = e_pid;
         rsp_cnt_in   = e_cnt;
         rsp_hit_in   = e_hit;
         rsp_ovf_in   = e_ovf;
         rsp_last_in  = e_last;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pattern_id  = rsp_pid_ff;
   assign rsp_ch.match_count = rsp_cnt_ff;
   assign rsp_ch.matched     = rsp_hit_ff;
   assign rsp_ch.overflow    = rsp_ovf_ff;
   assign rsp_ch.last        = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= acpc_pkg::ST_CLR;
         nodes_used_ff <= '0;
         pu_ff         <= '0;
         ins_node_ff   <= '0;
         ins_depth_ff  <= '0;
         ins_broken_ff <= 1'b0;
         built_ff      <= 1'b0;
         scan_node_ff  <= '0;
         lc_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         nodes_used_ff <= nodes_used_in;
         pu_ff         <= pu_in;
         ins_node_ff   <= ins_node_in;
         ins_depth_ff  <= ins_depth_in;
         ins_broken_ff <= ins_broken_in;
         built_ff      <= built_in;
         scan_node_ff  <= scan_node_in;
         lc_ff         <= lc_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      cmd_ff      <= cmd_in;
      ovf_ff      <= ovf_in;
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      n_ff        <= n_in;
      f_ff        <= f_in;
      ch_ff       <= ch_in;
      j_ff        <= j_in;
      pid_ff      <= pid_in;
      nc_ff       <= nc_in;
      k_ff        <= k_in;
      pend_pid_ff <= pend_pid_in;
      pend_cnt_ff <= pend_cnt_in;
      rsp_pid_ff  <= rsp_pid_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

>>> src/aho_corasick_pattern_counter.sv
// ----------------------------------------------------------------------------
// aho_corasick_pattern_counter
// Multi-pattern matcher: trie insert, link build, text scan, count read.
// ----------------------------------------------------------------------------
// Items are decoded into a two-entry command queue and executed one at a time
// by a sequencer over five RAMs, each with one write port and one registered
// read port (goto table, failure links, node patterns, counts, build queue).
// An insert that creates a node also zeroes the new goto row. A scan walks
// the failure chain and bumps the count of each pattern found. A build visits
// the root row first and then the goto row of each queued node.
// After reset and after a clear, the root row is zeroed, during which no item
// is taken.
module aho_corasick_pattern_counter #(
   parameter int ALPHABET        = acpc_pkg::ALPHABET_DEF,
   parameter int NODES           = acpc_pkg::NODES_DEF,
   parameter int PATTERNS        = acpc_pkg::PATTERNS_DEF,
   parameter int MAX_PATTERN_LEN = acpc_pkg::MAX_PATTERN_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   acpc_req_if.sink    req_ch,
   acpc_rsp_if.source  rsp_ch
);

   logic              cmd_valid;
   logic              cmd_ready;
   acpc_pkg::cmd_type cmd;
   logic              clearing;

   acpc_front #(
      .ALPHABET (ALPHABET),
      .PATTERNS (PATTERNS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .hold      (clearing),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   acpc_back #(
      .ALPHABET        (ALPHABET),
      .NODES           (NODES),
      .PATTERNS        (PATTERNS),
      .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .clearing  (clearing),
      .rsp_ch    (rsp_ch)
   );

endmodule
